// ===== src/bhsm_pkg.sv =====
// Package for the byte histogram with symbol map.
// Holds the sizes, the function codes and the shared types.
// Used by the channel interfaces, the valid map and the top module.
package bhsm_pkg;

  // Sizes of the histogram.
  localparam int SYMBOLS   = 256;
  localparam int MAX_COUNT = 1048576;
  localparam int IDX_W     = $clog2(SYMBOLS);
  localparam int SYM_W     = 8;
  localparam int FUNC_W    = 2;
  localparam int COUNT_W   = 21;
  localparam int DIST_W    = 9;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // Saturation limit of a bin count, below the full range of the bin width.
  localparam count_t COUNT_LIMIT = COUNT_W'(MAX_COUNT);

  // Function codes of an input item; the fourth code is a no-op.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Command to the valid-flag map from the update stage.
  typedef struct packed {
    logic set;
    logic clear;
    idx_t idx;
  } vmap_cmd_t;

endpackage

// ===== src/bhsm_ifs.sv =====
// Valid/ready channel interfaces of the byte histogram.
// Depends on bhsm_pkg for the payload widths.

// Input channel: one function code and one symbol per transfer.
interface bhsm_in_if;
  import bhsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

// Result channel: the answer to one read item per transfer.
interface bhsm_out_if;
  import bhsm_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic               bin_present;
  logic [DIST_W-1:0]  distinct_symbols;

  modport source (output valid, output bin_count, output bin_present,
                  output distinct_symbols, input ready);
  modport sink   (input valid, input bin_count, input bin_present,
                  input distinct_symbols, output ready);
endinterface

// ===== src/bhsm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered. No dependencies.
module bhsm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 21,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; old data when the same entry is written.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bhsm_valid_map.sv =====
// Per-bin valid flags and the count of distinct symbols.
// Depends on bhsm_pkg for sizes and the command struct.
module bhsm_valid_map (
  input  logic               clk,
  input  logic               rst_n,
  input  bhsm_pkg::vmap_cmd_t cmd,
  input  bhsm_pkg::idx_t     look_idx,
  output logic               look_valid,
  output bhsm_pkg::dist_t    distinct
);
  import bhsm_pkg::*;

  logic [SYMBOLS-1:0] valid_r, valid_nxt;
  dist_t              dist_r, dist_nxt;

  // A clear drops every flag at once; a set on a fresh bin adds one symbol.
  always_comb begin
    valid_nxt = valid_r;
    dist_nxt  = dist_r;
    if (cmd.clear) begin
      valid_nxt = '0;
      dist_nxt  = '0;
    end else if (cmd.set && !valid_r[cmd.idx]) begin
      valid_nxt[cmd.idx] = 1'b1;
      dist_nxt           = dist_r + DIST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dist_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      dist_r  <= dist_nxt;
    end
  end

  assign look_valid = valid_r[look_idx];
  assign distinct   = dist_r;

endmodule

// ===== src/byte_histogram_with_symbol_map.sv =====
// Byte histogram with symbol map. The block takes one item per clock cycle
// when the result side keeps up: a count adds one to its byte's bin
// (saturating), a read returns the bin's count, a presence flag and the
// number of distinct bytes, and a clear empties every bin at once through
// per-bin valid flags, so no clearing pass is needed after reset or a
// clear. Bin counts live in one RAM with a registered read; an item is
// accepted, its bin is read in the next cycle and written back at the end
// of it, with the last write forwarded to a following item on the same
// bin. A read result is registered when the read item leaves the update
// stage. The input waits only while a read result is ready to leave the
// stage and the result register still holds an untaken transfer.
module byte_histogram_with_symbol_map (
  input logic         clk,
  input logic         rst_n,
  bhsm_in_if.sink     in_ch,
  bhsm_out_if.source  out_ch
);
  import bhsm_pkg::*;

  // Update stage holding register.
  logic              s1_valid_r, s1_valid_nxt;
  logic [FUNC_W-1:0] s1_func_r;
  idx_t              s1_idx_r;

  // Forwarding of the write made at the edge the RAM was read.
  logic   fwd_valid_r, fwd_valid_nxt;
  idx_t   fwd_idx_r;
  count_t fwd_data_r;

  // Result register.
  logic   out_valid_r, out_valid_nxt;
  count_t out_count_r;
  logic   out_present_r;
  dist_t  out_dist_r;

  logic      in_fire, s1_go, s1_fire, s1_advance, res_load;
  logic      look_valid;
  dist_t     distinct;
  count_t    ram_rdata, cur_cnt, wr_data;
  logic      wr_en;
  vmap_cmd_t vcmd;

  assign in_fire = in_ch.valid && in_ch.ready;

  // Bin count storage.
  bhsm_ram #(
    .DEPTH (SYMBOLS),
    .WIDTH (COUNT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_ch.symbol[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  // Valid flags and distinct count.
  bhsm_valid_map u_vmap (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (vcmd),
    .look_idx   (s1_idx_r),
    .look_valid (look_valid),
    .distinct   (distinct)
  );

  // A read waits while the result register holds an untaken transfer.
  always_comb begin
    s1_go      = !(s1_valid_r && (s1_func_r == FUNC_READ) &&
                   out_valid_r && !out_ch.ready);
    s1_fire    = s1_valid_r && s1_go;
    s1_advance = !s1_valid_r || s1_go;
  end

  assign in_ch.ready = s1_advance;

  // Read-modify-write of the bin and the valid-map command.
  always_comb begin
    cur_cnt  = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : ram_rdata;
    wr_en    = 1'b0;
    wr_data  = cur_cnt;
    res_load = 1'b0;
    vcmd     = '{set: 1'b0, clear: 1'b0, idx: s1_idx_r};
    case (s1_func_r)
      FUNC_COUNT: begin
        wr_en    = s1_fire;
        vcmd.set = s1_fire;
        if (!look_valid) begin
          wr_data = COUNT_W'(1);
        end else if (cur_cnt < COUNT_LIMIT) begin
          wr_data = cur_cnt + COUNT_W'(1);
        end
      end
      FUNC_READ: begin
        res_load = s1_fire;
      end
      FUNC_CLEAR: begin
        vcmd.clear = s1_fire;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Next values of the control registers.
  always_comb begin
    s1_valid_nxt  = s1_advance ? in_fire : s1_valid_r;
    fwd_valid_nxt = s1_advance ? wr_en : fwd_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_ch.func;
      s1_idx_r  <= in_ch.symbol[IDX_W-1:0];
    end
    if (s1_advance) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= wr_data;
    end
    if (res_load) begin
      out_count_r   <= look_valid ? cur_cnt : '0;
      out_present_r <= look_valid;
      out_dist_r    <= distinct;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.bin_count        = out_count_r;
  assign out_ch.bin_present      = out_present_r;
  assign out_ch.distinct_symbols = out_dist_r;

  // The distinct count never exceeds the number of bins.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    distinct <= DIST_W'(SYMBOLS))
    else $error("distinct symbol count out of range");

  // A clear leaves no distinct symbols behind.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    vcmd.clear |=> (distinct == '0))
    else $error("distinct count not zero after clear");

  // An absent bin reports a zero count.
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_present_r) |-> (out_count_r == '0))
    else $error("absent bin reports nonzero count");

  // A waiting read holds the stage, so no new item can enter.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |-> !in_fire)
    else $error("item accepted while update stage stalled");

  // A counted bin never goes above the saturation limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_data <= COUNT_LIMIT))
    else $error("bin count above saturation limit");

endmodule

// ===== tb/byte_histogram_with_symbol_map_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the byte histogram with symbol map: directed items and random traffic
// under several idle and stall mixes, checked by a scoreboard.
// Depends on bhsm_pkg, the channel interfaces in bhsm_ifs.sv and the top module.
module byte_histogram_with_symbol_map_tb;
  import bhsm_pkg::*;

  // The fourth function code does nothing and gives no result.
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  // Answer of one read item.
  typedef struct packed {
    count_t cnt;
    logic   present;
    dist_t  distinct;
  } bin_answer_t;

  // Keeps its own copy of the histogram and the answers still owed by the block.
  class histogram_scoreboard;
    count_t      bin_cnt [SYMBOLS];
    bit          bin_live [SYMBOLS];
    dist_t       distinct_cnt;
    bin_answer_t answers_due [$];
    int          errors;

    function new();
      foreach (bin_live[i]) begin
        bin_live[i] = 1'b0;
        bin_cnt[i]  = '0;
      end
      distinct_cnt = '0;
      errors       = 0;
    endfunction

    // Applies one accepted input item and queues the answer of a read.
    function void note_input(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s);
      bin_answer_t a;
      int idx;
      idx = int'(s);
      case (f)
        FUNC_COUNT: begin
          if (idx < SYMBOLS) begin
            if (!bin_live[idx]) begin
              bin_live[idx] = 1'b1;
              bin_cnt[idx]  = count_t'(1);
              distinct_cnt  = distinct_cnt + dist_t'(1);
            end else if (bin_cnt[idx] < COUNT_LIMIT) begin
              bin_cnt[idx] = bin_cnt[idx] + count_t'(1);
            end
          end
        end
        FUNC_READ: begin
          a.cnt      = '0;
          a.present  = 1'b0;
          a.distinct = distinct_cnt;
          if (idx < SYMBOLS && bin_live[idx]) begin
            a.cnt     = bin_cnt[idx];
            a.present = 1'b1;
          end
          answers_due.push_back(a);
        end
        FUNC_CLEAR: begin
          foreach (bin_live[i]) bin_live[i] = 1'b0;
          distinct_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    // Compares one result transfer with the oldest answer owed.
    function void check_result(count_t c, logic p, dist_t d);
      bin_answer_t e;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: result with no read pending: bin_count %0d bin_present %0d distinct %0d",
                 $time, c, p, d);
        return;
      end
      e = answers_due.pop_front();
      if (c !== e.cnt) begin
        errors++;
        $display("%0t: bin_count expected %0d, actual %0d", $time, e.cnt, c);
      end
      if (p !== e.present) begin
        errors++;
        $display("%0t: bin_present expected %0d, actual %0d", $time, e.present, p);
      end
      if (d !== e.distinct) begin
        errors++;
        $display("%0t: distinct_symbols expected %0d, actual %0d", $time, e.distinct, d);
      end
    endfunction

    function int answers_waiting();
      return answers_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bhsm_in_if  in_ch ();
  bhsm_out_if out_ch ();

  byte_histogram_with_symbol_map u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  histogram_scoreboard sb;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  // Bins that have had a count since reset; only these are ever read.
  bit ever_counted [SYMBOLS];
  logic [SYM_W-1:0] last_sym   = '0;
  logic [SYM_W-1:0] sym_window = '0;

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: every transfer on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.bin_count, out_ch.bin_present, out_ch.distinct_symbols);
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.func, in_ch.symbol);
    end
  end

  // Offers one item after a random number of idle cycles and waits for its transfer.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid  <= 1'b0;
      in_ch.func   <= FUNC_W'($urandom);
      in_ch.symbol <= SYM_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.symbol <= s;
    if (f == FUNC_COUNT) ever_counted[s] = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly counts and reads on a few nearby bytes, so bins grow and the same
  // bin is often hit back to back; clears and no-ops are rare.
  task automatic send_random_item();
    int r;
    logic [FUNC_W-1:0] f;
    logic [SYM_W-1:0]  s;
    r = $urandom_range(99);
    case ($urandom_range(2))
      0:       s = last_sym;
      1:       s = sym_window ^ SYM_W'($urandom_range(15));
      default: s = SYM_W'($urandom);
    endcase
    if (r < 55)      f = FUNC_COUNT;
    else if (r < 93) f = FUNC_READ;
    else if (r < 95) f = FUNC_CLEAR;
    else             f = FUNC_NOP;
    if (f == FUNC_READ && !ever_counted[s]) f = FUNC_COUNT;
    if ($urandom_range(99) == 0) sym_window = SYM_W'($urandom);
    last_sym = s;
    send_item(f, s);
  endtask

  // Main sequence.
  initial begin
    logic [SYM_W-1:0] s;
    sb = new();
    foreach (ever_counted[i]) ever_counted[i] = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_COUNT;
    in_ch.symbol <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, first counts, repeat counts, no-ops and clears.
    send_item(FUNC_COUNT, 8'h00);
    send_item(FUNC_COUNT, 8'hFF);
    send_item(FUNC_COUNT, 8'h00);
    send_item(FUNC_READ,  8'h00);
    send_item(FUNC_READ,  8'hFF);
    send_item(FUNC_COUNT, 8'hAA);
    send_item(FUNC_COUNT, 8'h55);
    send_item(FUNC_READ,  8'hAA);
    send_item(FUNC_READ,  8'h55);
    send_item(FUNC_NOP,   8'h00);
    send_item(FUNC_NOP,   8'hFF);
    send_item(FUNC_READ,  8'h00);
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_READ,  8'h00);
    send_item(FUNC_READ,  8'hFF);
    send_item(FUNC_NOP,   8'hAA);
    send_item(FUNC_COUNT, 8'hFF);
    send_item(FUNC_READ,  8'hFF);
    send_item(FUNC_CLEAR, 8'hFF);

    // Random traffic in four idle and stall mixes; the first starts with a long receiver hold-off
    // while reads keep coming, so the block fills and stalls its input.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          hold_req      = hold_req + 1;
          repeat (120) begin
            do s = SYM_W'($urandom); while (!ever_counted[s]);
            send_item(FUNC_READ, s);
          end
        end
        1: begin
          src_idle_pct  = 52;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 52;
        end
        default: begin
          src_idle_pct  = 14;
          snk_stall_pct = 14;
        end
      endcase
      repeat (RANDOM_ITEMS / 4) send_random_item();
    end

    // Drain the remaining answers, then let the pipeline settle.
    in_ch.valid <= 1'b0;
    while (sb.answers_waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.answers_waiting() == 0) begin
      $display("byte_histogram_with_symbol_map_tb: done, clean");
    end else begin
      $display("byte_histogram_with_symbol_map_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: stops the run with an error report if it hangs.
  initial begin
    #2_000_000;
    $display("byte_histogram_with_symbol_map_tb: done, errors");
    $finish;
  end

endmodule
